[rtl/core/tpm_pkg.sv]
// Package: shared types and constants for the thermostat panel menu.
`timescale 1ns / 1ps

package tpm_pkg;

  typedef logic signed [7:0] tpm_temp_t;

  typedef enum logic [2:0] {
    MODE_TEMP     = 3'd0,
    MODE_SETPOINT = 3'd1,
    MODE_LOW      = 3'd2,
    MODE_HIGH     = 3'd3,
    MODE_TOO_HIGH = 3'd4,
    MODE_TOO_LOW  = 3'd5
  } tpm_mode_t;

  localparam tpm_temp_t SETPOINT_RESET = 8'sd7;
  localparam tpm_temp_t LOW_RESET      = -8'sd30;
  localparam tpm_temp_t HIGH_RESET     = 8'sd30;
  localparam tpm_temp_t SP_MAX         = 8'sd126;
  localparam tpm_temp_t SP_MIN         = -8'sd126;
  localparam tpm_temp_t BOUND_MAX      = 8'sd127;
  localparam tpm_temp_t BOUND_MIN      = -8'sd127;
  localparam tpm_temp_t ONE            = 8'sd1;

  // up, down, left, right from bit 0 up
  typedef logic [3:0] tpm_levels_t;

  typedef struct packed {
    tpm_mode_t   page;
    tpm_levels_t prev_levels;
    tpm_temp_t   setpoint;
    tpm_temp_t   low_bound;
    tpm_temp_t   high_bound;
  } tpm_state_t;

  typedef struct packed {
    tpm_levels_t levels;
    tpm_temp_t   temp;
  } tpm_item_t;

  typedef struct packed {
    tpm_temp_t high_bound;
    tpm_temp_t low_bound;
    tpm_temp_t setpoint;
    logic      buzzer_on;
    tpm_temp_t value;
    tpm_mode_t mode;
  } tpm_result_t;

endpackage

[rtl/core/tpm_step.sv]
// Step logic: next menu state and result for one tick.
`timescale 1ns / 1ps

module tpm_step #(
  parameter int BEEP_PERIOD  = 100,
  parameter int SETTLE_TICKS = 10,
  localparam int BW = $clog2(BEEP_PERIOD + 1),
  localparam int SW = (SETTLE_TICKS > 0) ? $clog2(SETTLE_TICKS + 1) : 1
) (
  input  tpm_pkg::tpm_item_t   item,
  input  tpm_pkg::tpm_state_t  state,
  input  logic [SW-1:0]        settle_count,
  input  logic [BW-1:0]        beep_count,
  output tpm_pkg::tpm_state_t  state_next,
  output logic [SW-1:0]        settle_count_next,
  output logic [BW-1:0]        beep_count_next,
  output tpm_pkg::tpm_result_t result
);

  always_comb begin
    tpm_pkg::tpm_levels_t edges;
    tpm_pkg::tpm_temp_t   sp;
    tpm_pkg::tpm_temp_t   lo;
    tpm_pkg::tpm_temp_t   hi;
    logic                 up, down, left, right;
    logic                 too_high, too_low;
    logic [BW-1:0]        beep_base;

    state_next        = state;
    settle_count_next = settle_count;
    beep_count_next   = beep_count;
    beep_base         = beep_count;
    sp = state.setpoint;
    lo = state.low_bound;
    hi = state.high_bound;

    if (settle_count < SW'(SETTLE_TICKS)) begin
      settle_count_next = settle_count + SW'(1);
      edges = '0;
    end else begin
      edges = item.levels & ~state.prev_levels;
      state_next.prev_levels = item.levels;
    end
    up    = edges[0];
    down  = edges[1];
    left  = edges[2];
    right = edges[3];

    too_high = item.temp > hi;
    too_low  = item.temp < lo;

    result.buzzer_on = 1'b0;
    result.mode      = tpm_pkg::MODE_TEMP;
    result.value     = item.temp;

    if (too_high || too_low) begin
      result.buzzer_on = beep_count >= BW'(BEEP_PERIOD / 4);
      beep_base = (beep_count == BW'(BEEP_PERIOD)) ? '0 : beep_count;
      beep_count_next = beep_base + BW'(1);
      result.mode = too_high ? tpm_pkg::MODE_TOO_HIGH : tpm_pkg::MODE_TOO_LOW;
      state_next.page = tpm_pkg::MODE_TEMP;
    end else begin
      case (state.page)
        tpm_pkg::MODE_SETPOINT: begin
          result.mode = tpm_pkg::MODE_SETPOINT;
          if (right) begin
            state_next.page = tpm_pkg::MODE_LOW;
          end else if (left) begin
            state_next.page = tpm_pkg::MODE_TEMP;
          end else begin
            if (up) begin
              if (sp < tpm_pkg::SP_MAX) sp = sp + tpm_pkg::ONE;
            end else if (down) begin
              if (sp > tpm_pkg::SP_MIN) sp = sp - tpm_pkg::ONE;
            end
            if (lo >= sp) lo = sp - tpm_pkg::ONE;
            else if (hi <= sp) hi = sp + tpm_pkg::ONE;
          end
          result.value = sp;
        end
        tpm_pkg::MODE_LOW: begin
          result.mode = tpm_pkg::MODE_LOW;
          if (right) begin
            state_next.page = tpm_pkg::MODE_HIGH;
          end else if (left) begin
            state_next.page = tpm_pkg::MODE_SETPOINT;
          end else begin
            if (up) begin
              if (lo < tpm_pkg::BOUND_MAX) lo = lo + tpm_pkg::ONE;
            end else if (down) begin
              if (lo > tpm_pkg::BOUND_MIN) lo = lo - tpm_pkg::ONE;
            end
            if (lo >= sp) lo = sp - tpm_pkg::ONE;
          end
          result.value = lo;
        end
        tpm_pkg::MODE_HIGH: begin
          result.mode = tpm_pkg::MODE_HIGH;
          if (right) begin
            state_next.page = tpm_pkg::MODE_TEMP;
          end else if (left) begin
            state_next.page = tpm_pkg::MODE_LOW;
          end else begin
            if (up) begin
              if (hi < tpm_pkg::BOUND_MAX) hi = hi + tpm_pkg::ONE;
            end else if (down) begin
              if (hi > tpm_pkg::BOUND_MIN) hi = hi - tpm_pkg::ONE;
            end
            if (hi <= sp) hi = sp + tpm_pkg::ONE;
          end
          result.value = hi;
        end
        default: begin
          result.mode = tpm_pkg::MODE_TEMP;
          if (right) state_next.page = tpm_pkg::MODE_SETPOINT;
          else if (left) state_next.page = tpm_pkg::MODE_HIGH;
          else state_next.page = tpm_pkg::MODE_TEMP;
        end
      endcase
    end

    state_next.setpoint   = sp;
    state_next.low_bound  = lo;
    state_next.high_bound = hi;
    result.setpoint   = sp;
    result.low_bound  = lo;
    result.high_bound = hi;
  end

endmodule

[rtl/core/thermostat_panel_menu.sv]
// Top level: thermostat panel menu with stream input and output registers.
`timescale 1ns / 1ps

// Accepts one tick (button levels and temperature) per clock cycle while
// the output is not held. A tick sits in the input register while one
// pass of step logic computes its result and the new menu state, both
// taken at once into the output register, so consecutive ticks follow
// back to back. Backpressure on the output holds the input register and
// then drops s_axis_tready.
module thermostat_panel_menu #(
  parameter int BEEP_PERIOD  = 100,
  parameter int SETTLE_TICKS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] up_button, [1] down_button, [2] left_button, [3] right_button,
  // [11:4] measured_temp, [15:12] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] display_mode, [10:3] display_value, [11] buzzer_on,
  // [19:12] setpoint_out, [27:20] low_bound_out, [35:28] high_bound_out,
  // [39:36] zero
  output logic [39:0] m_axis_tdata
);

  localparam int BW = $clog2(BEEP_PERIOD + 1);
  localparam int SW = (SETTLE_TICKS > 0) ? $clog2(SETTLE_TICKS + 1) : 1;

  logic                 in_valid;
  tpm_pkg::tpm_item_t   in_item;
  logic                 out_valid;
  tpm_pkg::tpm_result_t out_result;

  tpm_pkg::tpm_state_t  state;
  tpm_pkg::tpm_state_t  state_next;
  logic [SW-1:0]        settle_count;
  logic [SW-1:0]        settle_count_next;
  logic [BW-1:0]        beep_count;
  logic [BW-1:0]        beep_count_next;
  tpm_pkg::tpm_result_t result_next;

  logic out_free;
  logic advance;
  logic accept;

  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tpm_step #(
    .BEEP_PERIOD  (BEEP_PERIOD),
    .SETTLE_TICKS (SETTLE_TICKS)
  ) u_step (
    .item              (in_item),
    .state             (state),
    .settle_count      (settle_count),
    .beep_count        (beep_count),
    .state_next        (state_next),
    .settle_count_next (settle_count_next),
    .beep_count_next   (beep_count_next),
    .result            (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid              <= 1'b0;
      out_valid             <= 1'b0;
      state.page            <= tpm_pkg::MODE_TEMP;
      state.prev_levels     <= '0;
      state.setpoint        <= tpm_pkg::SETPOINT_RESET;
      state.low_bound       <= tpm_pkg::LOW_RESET;
      state.high_bound      <= tpm_pkg::HIGH_RESET;
      settle_count          <= '0;
      beep_count            <= '0;
    end else begin
      if (accept) in_valid <= 1'b1;
      else if (advance) in_valid <= 1'b0;

      if (advance) begin
        out_valid    <= 1'b1;
        state        <= state_next;
        settle_count <= settle_count_next;
        beep_count   <= beep_count_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item.levels <= s_axis_tdata[3:0];
      in_item.temp   <= s_axis_tdata[11:4];
    end
    if (advance) out_result <= result_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_result};

endmodule
